>>> rtl/core/fird_pkg.sv
package fird_pkg;

  // Widths of the fields that do not follow from the top-level parameters.
  localparam int ACT_W      = 2;
  localparam int IDX_W      = 10;
  localparam int DF_W       = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // Register reset values and limits.
  localparam int DF_RST = 10;
  localparam int TC_RST = 201;
  localparam int TC_MIN = 3;

  // Depth of the command queue between front and back; a power of two.
  localparam int QDEPTH = 4;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH    = 2'd0,
    ACT_LOAD    = 2'd1,
    ACT_RESTART = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    CMD_PUSH,
    CMD_PASS,
    CMD_LOAD,
    CMD_RESTART
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DECIM  = 2'd0,
    CFG_TAPS   = 2'd1,
    CFG_BYPASS = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_OUT
  } back_state_t;

endpackage

>>> rtl/core/fir_decimator.sv
// A bypassed sample passes from the command queue to the output register; a filtered
// output is formed in the MAC, DRAIN and OUT states after the sample that triggers it.
// Loads, restarts, bypassed and non-emitting samples are handled from the idle state of the
// back end; an emitting sample holds it through MAC, one tap per cycle, then DRAIN and OUT.
// Reset (synchronous, rst_n low) loads the register defaults and empties the fill;
// tap and history RAM contents are undefined until written and are not cleared.
module fir_decimator import fird_pkg::*; #(
  parameter int MAX_TAPS    = 1024,
  parameter int SAMPLE_BITS = 24,
  parameter int COEFF_BITS  = 18,
  localparam int IN_DATA_W  = ((SAMPLE_BITS + IDX_W + COEFF_BITS + 7) / 8) * 8,
  localparam int OUT_DATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // sample_in, coeff_index, coeff_value, zero pad
  input  logic [ACT_W-1:0]      in_tuser,   // action
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // sample_out, zero pad
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int TC_W     = $clog2(MAX_TAPS + 1);
  localparam int TC_RST_V = (TC_RST > MAX_TAPS) ? MAX_TAPS : TC_RST;

  logic [DF_W-1:0]        decim_r, decim_nxt;
  logic [TC_W-1:0]        tap_count_r, tap_count_nxt;
  logic                   bypass_r, bypass_nxt;
  logic [TC_W-1:0]        tc_sat;
  logic                   tc_wr;

  logic                   q_valid, q_pop;
  cmd_t                   q_kind;
  logic [SAMPLE_BITS-1:0] q_sample;
  logic [IDX_W-1:0]       q_cidx;
  logic [COEFF_BITS-1:0]  q_cval;
  logic [SAMPLE_BITS-1:0] out_sample;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (cfg_data < CFG_DATA_W'(TC_MIN)) begin
      tc_sat = TC_W'(TC_MIN);
    end else if (int'(cfg_data) > MAX_TAPS) begin
      tc_sat = TC_W'(MAX_TAPS);
    end else begin
      tc_sat = TC_W'(cfg_data);
    end
  end

  always_comb begin
    decim_nxt     = decim_r;
    tap_count_nxt = tap_count_r;
    bypass_nxt    = bypass_r;
    tc_wr         = 1'b0;
    if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_DECIM: begin
          decim_nxt = cfg_data[DF_W-1:0];
        end
        CFG_TAPS: begin
          tap_count_nxt = tc_sat;
          tc_wr         = 1'b1;
        end
        CFG_BYPASS: begin
          bypass_nxt = cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decim_r     <= DF_W'(DF_RST);
      tap_count_r <= TC_W'(TC_RST_V);
      bypass_r    <= 1'b0;
    end else begin
      decim_r     <= decim_nxt;
      tap_count_r <= tap_count_nxt;
      bypass_r    <= bypass_nxt;
    end
  end

  fird_front #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEFF_BITS  (COEFF_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_action (in_tuser),
    .in_sample (in_tdata[SAMPLE_BITS-1:0]),
    .in_cidx   (in_tdata[SAMPLE_BITS +: IDX_W]),
    .in_cval   (in_tdata[SAMPLE_BITS + IDX_W +: COEFF_BITS]),
    .bypass    (bypass_r),
    .q_valid   (q_valid),
    .q_kind    (q_kind),
    .q_sample  (q_sample),
    .q_cidx    (q_cidx),
    .q_cval    (q_cval),
    .q_pop     (q_pop)
  );

  fird_back #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEFF_BITS  (COEFF_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_kind     (q_kind),
    .q_sample   (q_sample),
    .q_cidx     (q_cidx),
    .q_cval     (q_cval),
    .q_pop      (q_pop),
    .tap_count  (tap_count_r),
    .decim      (decim_r),
    .tc_wr      (tc_wr),
    .tc_new     (tc_sat),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_sample (out_sample)
  );

  assign out_tdata = OUT_DATA_W'(out_sample);

endmodule

>>> rtl/core/fird_ram.sv
module fird_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/fird_front.sv
module fird_front import fird_pkg::*; #(
  parameter int MAX_TAPS    = 1024,
  parameter int SAMPLE_BITS = 24,
  parameter int COEFF_BITS  = 18
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [ACT_W-1:0]       in_action,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic [IDX_W-1:0]       in_cidx,
  input  logic [COEFF_BITS-1:0]  in_cval,
  input  logic                   bypass,
  output logic                   q_valid,
  output cmd_t                   q_kind,
  output logic [SAMPLE_BITS-1:0] q_sample,
  output logic [IDX_W-1:0]       q_cidx,
  output logic [COEFF_BITS-1:0]  q_cval,
  input  logic                   q_pop
);

  localparam int ENT_W = 2 + SAMPLE_BITS + IDX_W + COEFF_BITS;
  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  logic [ENT_W-1:0] q_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             keep;
  logic             push;
  cmd_t             kind;
  logic [ENT_W-1:0] head;

  // Classify the item; unused actions and out-of-range tap loads never enter the queue.
  always_comb begin
    keep = 1'b1;
    kind = CMD_PUSH;
    unique case (action_t'(in_action))
      ACT_PUSH: begin
        kind = bypass ? CMD_PASS : CMD_PUSH;
      end
      ACT_LOAD: begin
        kind = CMD_LOAD;
        keep = int'(in_cidx) < MAX_TAPS;
      end
      ACT_RESTART: begin
        kind = CMD_RESTART;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_ready = cnt_r != CNT_W'(QDEPTH);
  assign push     = in_valid && in_ready && keep;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= {kind, in_sample, in_cidx, in_cval};
    end
  end

  assign head     = q_r[rd_ptr_r];
  assign q_valid  = cnt_r != '0;
  assign q_kind   = cmd_t'(head[ENT_W-1 -: 2]);
  assign q_sample = head[IDX_W + COEFF_BITS +: SAMPLE_BITS];
  assign q_cidx   = head[COEFF_BITS +: IDX_W];
  assign q_cval   = head[COEFF_BITS-1:0];

endmodule

>>> rtl/core/fird_back.sv
module fird_back import fird_pkg::*; #(
  parameter int MAX_TAPS    = 1024,
  parameter int SAMPLE_BITS = 24,
  parameter int COEFF_BITS  = 18,
  localparam int TC_W = $clog2(MAX_TAPS + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  cmd_t                   q_kind,
  input  logic [SAMPLE_BITS-1:0] q_sample,
  input  logic [IDX_W-1:0]       q_cidx,
  input  logic [COEFF_BITS-1:0]  q_cval,
  output logic                   q_pop,
  input  logic [TC_W-1:0]        tap_count,
  input  logic [DF_W-1:0]        decim,
  input  logic                   tc_wr,
  input  logic [TC_W-1:0]        tc_new,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_BITS-1:0] out_sample
);

  localparam int AW       = $clog2(MAX_TAPS);
  localparam int PROD_W   = SAMPLE_BITS + COEFF_BITS;
  localparam int FULL_W   = PROD_W + AW + 1;
  localparam int ACC_W    = (FULL_W > 64) ? 64 : FULL_W;
  localparam int TC_RST_V = (TC_RST > MAX_TAPS) ? MAX_TAPS : TC_RST;

  localparam logic signed [ACC_W-1:0] RND  = ACC_W'(1) << (COEFF_BITS - 2);
  localparam logic signed [ACC_W-1:0] MAXV = (ACC_W'(1) << (SAMPLE_BITS - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] MINV = ~MAXV;

  back_state_t               state_r, state_nxt;
  logic [AW-1:0]             oldest_r, oldest_nxt;
  logic [TC_W-1:0]           fill_r, fill_nxt;
  logic [DF_W-1:0]           skip_r, skip_nxt;
  logic [TC_W-1:0]           cnt_r, cnt_nxt;
  logic [AW-1:0]             pos_r, pos_nxt;
  logic                      rd_v_r, rd_v_nxt;
  logic                      mul_v_r, mul_v_nxt;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [SAMPLE_BITS-1:0]    out_data_r, out_data_nxt;

  logic                      t_we, h_we, rd_en;
  logic [AW-1:0]             t_waddr, h_waddr;
  logic [COEFF_BITS-1:0]     t_rdata;
  logic [SAMPLE_BITS-1:0]    h_rdata;

  logic                      res_free;
  logic [DF_W-1:0]           factor;
  logic [TC_W-1:0]           fill_dec, fill_idx, old_inc, pos_inc;
  logic [AW-1:0]             old_wrap, pos_wrap;
  logic [DF_W-1:0]           skip_dec;
  logic signed [ACC_W-1:0]   rnd, shr;
  logic [SAMPLE_BITS-1:0]    sat_val;

  fird_ram #(
    .WIDTH (COEFF_BITS),
    .DEPTH (MAX_TAPS)
  ) u_taps (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (q_cval),
    .re    (rd_en),
    .raddr (cnt_r[AW-1:0]),
    .rdata (t_rdata)
  );

  fird_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_TAPS)
  ) u_hist (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (q_sample),
    .re    (rd_en),
    .raddr (pos_r),
    .rdata (h_rdata)
  );

  assign res_free = !out_valid_r || out_ready;
  assign factor   = (decim == '0) ? DF_W'(1) : decim;
  assign fill_dec = fill_r - 1'b1;
  assign fill_idx = tap_count - fill_r;
  assign old_inc  = TC_W'(oldest_r) + 1'b1;
  assign old_wrap = (old_inc >= tap_count) ? '0 : old_inc[AW-1:0];
  assign pos_inc  = TC_W'(pos_r) + 1'b1;
  assign pos_wrap = (pos_inc >= tap_count) ? '0 : pos_inc[AW-1:0];
  assign skip_dec = (skip_r != '0) ? skip_r - 1'b1 : '0;
  assign t_waddr  = AW'(q_cidx);

  // Round to nearest with ties toward +inf, then clamp to the sample range.
  always_comb begin
    rnd = acc_r + RND;
    shr = rnd >>> (COEFF_BITS - 1);
    if (shr > MAXV) begin
      sat_val = MAXV[SAMPLE_BITS-1:0];
    end else if (shr < MINV) begin
      sat_val = MINV[SAMPLE_BITS-1:0];
    end else begin
      sat_val = shr[SAMPLE_BITS-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    oldest_nxt    = oldest_r;
    fill_nxt      = fill_r;
    skip_nxt      = skip_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    t_we          = 1'b0;
    h_we          = 1'b0;
    h_waddr       = oldest_r;
    rd_en         = 1'b0;

    // Multiply-accumulate pipeline: RAM read, product register, accumulator.
    rd_v_nxt  = 1'b0;
    mul_v_nxt = rd_v_r;
    prod_nxt  = prod_r;
    acc_nxt   = acc_r;
    if (rd_v_r) begin
      prod_nxt = $signed(h_rdata) * $signed(t_rdata);
    end
    if (mul_v_r) begin
      acc_nxt = acc_r + ACC_W'(prod_r);
    end

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          unique case (q_kind)
            CMD_LOAD: begin
              q_pop = 1'b1;
              t_we  = 1'b1;
            end
            CMD_RESTART: begin
              q_pop      = 1'b1;
              fill_nxt   = tap_count;
              oldest_nxt = '0;
              skip_nxt   = '0;
            end
            CMD_PASS: begin
              if (res_free) begin
                q_pop         = 1'b1;
                out_valid_nxt = 1'b1;
                out_data_nxt  = q_sample;
              end
            end
            CMD_PUSH: begin
              q_pop = 1'b1;
              h_we  = 1'b1;
              if (fill_r != '0) begin
                h_waddr  = fill_idx[AW-1:0];
                fill_nxt = fill_dec;
                if (fill_dec == '0) begin
                  oldest_nxt = '0;
                  skip_nxt   = factor;
                  state_nxt  = ST_MAC;
                  cnt_nxt    = '0;
                  pos_nxt    = '0;
                  acc_nxt    = '0;
                end
              end else begin
                oldest_nxt = old_wrap;
                skip_nxt   = skip_dec;
                if (skip_dec == '0) begin
                  skip_nxt  = factor;
                  state_nxt = ST_MAC;
                  cnt_nxt   = '0;
                  pos_nxt   = old_wrap;
                  acc_nxt   = '0;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_MAC: begin
        rd_en    = 1'b1;
        rd_v_nxt = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        pos_nxt  = pos_wrap;
        if (cnt_r == tap_count - 1'b1) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_v_r && !mul_v_r) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (res_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = sat_val;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Tap count writes restart the fill; user keeps them to idle, not the block.
    if (tc_wr) begin
      fill_nxt   = tc_new;
      oldest_nxt = '0;
      skip_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      oldest_r    <= '0;
      fill_r      <= TC_W'(TC_RST_V);
      skip_r      <= '0;
      cnt_r       <= '0;
      pos_r       <= '0;
      rd_v_r      <= 1'b0;
      mul_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      oldest_r    <= oldest_nxt;
      fill_r      <= fill_nxt;
      skip_r      <= skip_nxt;
      cnt_r       <= cnt_nxt;
      pos_r       <= pos_nxt;
      rd_v_r      <= rd_v_nxt;
      mul_v_r     <= mul_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_data_r;

endmodule

>>> sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fird_pkg::*;

  localparam int MAX_TAPS    = 1024;
  localparam int SAMPLE_BITS = 24;
  localparam int COEFF_BITS  = 18;
  localparam int IN_DATA_W   = ((SAMPLE_BITS + IDX_W + COEFF_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int STALL_LIMIT = 20000;

  localparam logic [ACT_W-1:0]     ACT_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [COEFF_BITS-1:0]  COEFF_MAX  = {1'b0, {(COEFF_BITS-1){1'b1}}};
  localparam logic [COEFF_BITS-1:0]  COEFF_MIN  = {1'b1, {(COEFF_BITS-1){1'b0}}};
  localparam logic [COEFF_BITS-1:0]  COEFF_HALF = COEFF_BITS'(1 << (COEFF_BITS - 2));
  localparam longint SAT_HI = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint SAT_LO = -(longint'(1) << (SAMPLE_BITS - 1));

  typedef struct packed {
    logic [ACT_W-1:0]       act;
    logic [SAMPLE_BITS-1:0] sample;
    logic [IDX_W-1:0]       cidx;
    logic [COEFF_BITS-1:0]  cval;
  } fir_item_t;

  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_BURSTY} rx_pattern_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // sample_in, coeff_index, coeff_value, zero pad
  logic [ACT_W-1:0]      in_tuser = '0;   // action
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // sample_out, zero pad
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  fir_decimator #(
    .MAX_TAPS(MAX_TAPS),
    .SAMPLE_BITS(SAMPLE_BITS),
    .COEFF_BITS(COEFF_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Filter state as the block should hold it.
  logic signed [SAMPLE_BITS-1:0] hist_mem [MAX_TAPS];
  logic signed [COEFF_BITS-1:0]  tap_mem [MAX_TAPS];
  bit                            tap_planned [MAX_TAPS];
  int unsigned decim_reg, ntaps, oldest_pos, fill_left, skip_left;
  bit          bypass_reg;

  fir_item_t              pending_items [$];
  logic [SAMPLE_BITS-1:0] expected_samples [$];
  fir_item_t              cur_item;
  int                     burst_left = 0;
  int                     gap_left = 0;
  int                     err_count = 0;
  int                     quiet_cycles = 0;
  rx_pattern_t            ready_mode = RX_OPEN;
  int                     ready_hold = 0;
  int unsigned            ready_phase = 0;
  logic signed [SAMPLE_BITS-1:0] out_got, out_want;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void restart_fill();
    fill_left = ntaps;
    oldest_pos = 0;
    skip_left = 0;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] tap_dot_product();
    longint      acc;
    longint      r;
    int unsigned p;
    int unsigned i;
    acc = 0;
    p = oldest_pos;
    for (i = 0; i < ntaps; i++) begin
      acc += longint'(tap_mem[i]) * longint'(hist_mem[p]);
      p = (p + 1 >= ntaps) ? 0 : p + 1;
    end
    // Round half toward +inf, then clamp to the sample range.
    r = (acc + (longint'(1) << (COEFF_BITS - 2))) >>> (COEFF_BITS - 1);
    if (r > SAT_HI) r = SAT_HI;
    else if (r < SAT_LO) r = SAT_LO;
    return r[SAMPLE_BITS-1:0];
  endfunction

  task automatic decimate_step(input fir_item_t it);
    int unsigned factor;
    factor = (decim_reg == 0) ? 1 : decim_reg;
    case (it.act)
      ACT_LOAD: tap_mem[it.cidx] = it.cval;
      ACT_RESTART: restart_fill();
      ACT_PUSH: begin
        if (bypass_reg) begin
          expected_samples.push_back(it.sample);
        end else if (fill_left > 0) begin
          hist_mem[ntaps - fill_left] = it.sample;
          fill_left--;
          if (fill_left == 0) begin
            oldest_pos = 0;
            skip_left = factor;
            expected_samples.push_back(tap_dot_product());
          end
        end else begin
          hist_mem[oldest_pos] = it.sample;
          oldest_pos = (oldest_pos + 1 >= ntaps) ? 0 : oldest_pos + 1;
          if (skip_left > 0) skip_left--;
          if (skip_left == 0) begin
            skip_left = factor;
            expected_samples.push_back(tap_dot_product());
          end
        end
      end
      default: ;
    endcase
  endtask

  function automatic logic [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2, 3, 4: return SAMPLE_BITS'($urandom_range(64) - 32);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  task automatic queue_item(input logic [ACT_W-1:0] act, input logic [SAMPLE_BITS-1:0] smp,
                            input logic [IDX_W-1:0] idx, input logic [COEFF_BITS-1:0] val);
    fir_item_t it;
    it = '{act: act, sample: smp, cidx: idx, cval: val};
    if (act == ACT_LOAD) tap_planned[idx] = 1'b1;
    pending_items.push_back(it);
  endtask

  task automatic add_random_item(input bit allow_restart);
    int                    pick;
    logic [ACT_W-1:0]      act;
    logic [COEFF_BITS-1:0] val;
    pick = $urandom_range(99);
    if (pick < 80) act = ACT_PUSH;
    else if (pick < 90) act = ACT_LOAD;
    else if (pick < 95) act = allow_restart ? ACT_RESTART : ACT_PUSH;
    else act = ACT_UNUSED;
    case ($urandom_range(7))
      0: val = COEFF_MAX;
      1: val = COEFF_MIN;
      default: val = COEFF_BITS'($urandom);
    endcase
    queue_item(act, rand_sample(), IDX_W'($urandom), val);
  endtask

  // Wait until every item is in, every output is out, and the back end has had
  // time to finish a filter pass that produces nothing.
  task automatic settle();
    while (pending_items.size() != 0 || in_tvalid || expected_samples.size() != 0)
      @(posedge clk);
    repeat (ntaps + 16) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_DECIM: decim_reg = data[DF_W-1:0];
      CFG_TAPS: begin
        ntaps = (data < TC_MIN) ? TC_MIN : ((data > MAX_TAPS) ? MAX_TAPS : data);
        restart_fill();
      end
      CFG_BYPASS: bypass_reg = data[0];
      default: ;
    endcase
  endtask

  // A negative setting leaves that register alone. Every tap in use gets
  // loaded before the first sample of the phase.
  task automatic run_phase(input int decim_w, input int taps_w, input int byp_w, input int n,
                           input bit allow_restart);
    int unsigned i;
    settle();
    if (decim_w >= 0)
      write_reg(CFG_DECIM, CFG_DATA_W'(($urandom_range(15) << DF_W) | decim_w));
    if (taps_w >= 0)
      write_reg(CFG_TAPS, CFG_DATA_W'(taps_w));
    if (byp_w >= 0)
      write_reg(CFG_BYPASS, CFG_DATA_W'(($urandom_range(1023) << 1) | byp_w));
    cfg_valid <= 1'b0;
    for (i = 0; i < ntaps; i++)
      if (!tap_planned[i]) queue_item(ACT_LOAD, rand_sample(), IDX_W'(i), COEFF_BITS'($urandom));
    repeat (n) add_random_item(allow_restart);
  endtask

  initial begin
    decim_reg = DF_RST;
    ntaps = TC_RST;
    bypass_reg = 1'b0;
    restart_fill();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset defaults: odd actions first, then a long fill at 201 taps.
    queue_item(ACT_UNUSED, SAMPLE_MAX, '1, COEFF_MAX);
    queue_item(ACT_RESTART, '0, '0, '0);
    queue_item(ACT_LOAD, '0, '1, COEFF_MIN);
    run_phase(-1, -1, -1, 350, 1'b0);

    // Saturation in both directions on a three-tap filter.
    run_phase(2, 3, 0, 0, 1'b0);
    repeat (3) queue_item(ACT_LOAD, '0, '0, COEFF_MAX);
    queue_item(ACT_LOAD, '0, IDX_W'(1), COEFF_MAX);
    queue_item(ACT_LOAD, '0, IDX_W'(2), COEFF_MAX);
    repeat (3) queue_item(ACT_PUSH, SAMPLE_MAX, '0, '0);
    repeat (2) queue_item(ACT_PUSH, SAMPLE_MIN, '0, '0);
    queue_item(ACT_LOAD, '0, IDX_W'(0), COEFF_MIN);
    queue_item(ACT_LOAD, '0, IDX_W'(1), COEFF_MIN);
    queue_item(ACT_LOAD, '0, IDX_W'(2), COEFF_MIN);
    repeat (2) queue_item(ACT_PUSH, SAMPLE_MIN, '0, '0);
    repeat (2) queue_item(ACT_PUSH, SAMPLE_MAX, '0, '0);
    // Half-way sums: plus one half rounds up, minus one half rounds to zero.
    queue_item(ACT_LOAD, '0, IDX_W'(0), COEFF_HALF);
    queue_item(ACT_LOAD, '0, IDX_W'(1), '0);
    queue_item(ACT_LOAD, '0, IDX_W'(2), '0);
    queue_item(ACT_RESTART, '0, '0, '0);
    queue_item(ACT_PUSH, SAMPLE_BITS'(1), '0, '0);
    repeat (3) queue_item(ACT_PUSH, '1, '0, '0);
    queue_item(ACT_PUSH, SAMPLE_BITS'(3), '0, '0);
    queue_item(ACT_UNUSED, '0, '0, '0);
    queue_item(ACT_PUSH, '0, '0, '0);

    // Bypass in the middle of a running stream.
    run_phase(-1, -1, 1, 0, 1'b0);
    queue_item(ACT_PUSH, SAMPLE_MAX, '0, '0);
    queue_item(ACT_PUSH, SAMPLE_MIN, '0, '0);
    queue_item(ACT_PUSH, '1, '0, '0);
    queue_item(ACT_UNUSED, '0, '0, '0);

    run_phase(0, 5, 0, 150, 1'b1);
    run_phase(1, 0, -1, 150, 1'b1);
    run_phase(127, 4, -1, 300, 1'b1);
    // A new factor while a long countdown is still running.
    run_phase(5, -1, -1, 100, 1'b1);
    run_phase(64, 16, 1, 80, 1'b1);
    settle();
    write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
    write_reg(CFG_BYPASS, '0);
    // The tap count clamps to the maximum, so these samples never complete the fill.
    write_reg(CFG_TAPS, CFG_DATA_W'(2047));
    cfg_valid <= 1'b0;
    repeat (100) add_random_item(1'b0);
    repeat (2) run_phase($urandom_range(20), $urandom_range(3, 40), 0, 200, 1'b1);

    settle();
    if (err_count == 0 && expected_samples.size() == 0)
      $display("fir_decimator regression: pass");
    else
      $display("fir_decimator regression: fail");
    $finish;
  end

  // Sender: bursts of items with random gaps between them.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        decimate_step(cur_item);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) gap_left = ($urandom_range(9) < 3) ? 0 : $urandom_range(1, 24);
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          cur_item = pending_items.pop_front();
          in_tuser <= cur_item.act;
          in_tdata <= IN_DATA_W'({cur_item.cval, cur_item.cidx, cur_item.sample});
          in_tvalid <= 1'b1;
          if (burst_left == 0) burst_left = $urandom_range(1, 32);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: switches between several stall patterns.
  always @(posedge clk) begin
    if (ready_hold == 0) begin
      ready_mode = rx_pattern_t'($urandom_range(3));
      ready_hold = $urandom_range(20, 200);
    end else begin
      ready_hold--;
    end
    ready_phase++;
    case (ready_mode)
      RX_OPEN: out_tready <= 1'b1;
      RX_COIN: out_tready <= 1'($urandom_range(1));
      RX_SPARSE: out_tready <= (ready_phase % 4 == 0);
      default: out_tready <= (ready_phase % 16 >= 10);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      out_got = out_tdata[SAMPLE_BITS-1:0];
      if (expected_samples.size() == 0) begin
        $display("%0t: output item with none expected, got %0d", $time, out_got);
        err_count++;
      end else begin
        out_want = expected_samples.pop_front();
        if (out_got !== out_want) begin
          $display("%0t: sample_out mismatch, expected %0d, got %0d", $time, out_want, out_got);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("fir_decimator regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
